>>> sv/unix_time_to_zoned_date_time_macros.svh
// Assertion helpers used by the block's controller module.
// Each macro expects clk and the active-low reset rst_n in scope.
`ifndef UNIX_TIME_TO_ZONED_DATE_TIME_MACROS_SVH
`define UNIX_TIME_TO_ZONED_DATE_TIME_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTZ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UTZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/utz_pkg.sv
package utz_pkg;

  // Default number of zone table entries.
  localparam int ZONE_COUNT_DEF = 16;

  // Calendar origin of the count.
  localparam int EPOCH_YEAR = 1970;

  // Field widths.
  localparam int TS_W     = 32;
  localparam int ZI_W     = 4;
  localparam int OFF_W    = 5;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  // Day count since the epoch fits in 16 bits for any 32-bit timestamp.
  localparam int DAYS_W = 16;

  // Phase counter of each division: estimate first, then correction.
  localparam int CNT_W = 1;
  localparam logic [CNT_W-1:0] DIV_TOP = CNT_W'(1);

  localparam logic [TS_W-1:0] SECS_PER_DAY  = TS_W'(86400);
  localparam logic [TS_W-1:0] SECS_PER_HOUR = TS_W'(3600);
  localparam logic [TS_W-1:0] SECS_PER_MIN  = TS_W'(60);

  // Reciprocals for the quotient estimates. A day is 675 * 2^7 seconds, so the
  // day estimate works on the stamp without its low 7 bits. Each reciprocal is
  // floor(2^SH / divisor), with SH the width of its numerator, which keeps the
  // estimate exact or one below the true quotient.
  localparam int DAY_PRE      = 7;
  localparam int DAY_SH       = TS_W - DAY_PRE;
  localparam int DAY_RECIP_W  = 16;
  localparam logic [DAY_RECIP_W-1:0] DAY_RECIP = DAY_RECIP_W'(49710);
  localparam int HOUR_SH      = 17;
  localparam int HOUR_RECIP_W = 6;
  localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP = HOUR_RECIP_W'(36);
  localparam int MIN_SH       = 12;
  localparam int MIN_RECIP_W  = 7;
  localparam logic [MIN_RECIP_W-1:0] MIN_RECIP = MIN_RECIP_W'(68);

  localparam logic [MONTH_W-1:0] LAST_MONTH = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] FEBRUARY   = MONTH_W'(1);

  // Which constant divisor the shared divider uses.
  typedef enum logic [1:0] {
    DS_DAY  = 2'd0,
    DS_HOUR = 2'd1,
    DS_MIN  = 2'd2
  } div_sel_t;

  // Controller states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_ADD      = 8'b0000_0010,
    S_DIV_DAY  = 8'b0000_0100,
    S_DIV_HOUR = 8'b0000_1000,
    S_DIV_MIN  = 8'b0001_0000,
    S_YEAR     = 8'b0010_0000,
    S_MONTH    = 8'b0100_0000,
    S_FINISH   = 8'b1000_0000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             wr;
    logic             load;
    logic             add;
    logic             div_en;
    div_sel_t         div_sel;
    logic             div_fix;
    logic             year_en;
    logic             month_en;
    logic             out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic year_done;
    logic month_done;
  } sts_t;

  // Length of a month (0 is January) in days.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      FEBRUARY:                  len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

>>> sv/utz_dp.sv
module utz_dp
  import utz_pkg::*;
#(
  parameter int ZONE_COUNT = ZONE_COUNT_DEF
) (
  input  logic                clk,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [TS_W-1:0]     in_unix_time,
  input  logic [ZI_W-1:0]     in_zone_index,
  input  logic [OFF_W-1:0]    in_zone_offset_hours,
  output logic [YEAR_W-1:0]   out_year,
  output logic [MONTH_W-1:0]  out_month,
  output logic [DAY_W-1:0]    out_day,
  output logic [HOUR_W-1:0]   out_hour,
  output logic [MINUTE_W-1:0] out_minute,
  output logic [SECOND_W-1:0] out_second,
  output logic [ZI_W-1:0]     out_zone_used
);

  localparam int AW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
  localparam logic [6:0] MOD100_INIT = 7'(EPOCH_YEAR % 100);
  localparam logic [8:0] MOD400_INIT = 9'(EPOCH_YEAR % 400);
  localparam int EST_DAY_W  = DAY_SH + DAY_RECIP_W;
  localparam int EST_HOUR_W = HOUR_SH + HOUR_RECIP_W;
  localparam int EST_MIN_W  = MIN_SH + MIN_RECIP_W;

  // Zone offset table, written by table write transactions, read with a registered port.
  logic [OFF_W-1:0] zone_mem [ZONE_COUNT];
  logic [AW-1:0]    zone_addr;
  logic             zone_ok;
  logic [OFF_W-1:0] off_r;
  logic             ok_r;

  // Working registers.
  logic [TS_W-1:0]     ts_r;
  logic [ZI_W-1:0]     zi_r;
  logic [TS_W-1:0]     rem_r, rem_nxt;
  logic [DAYS_W-1:0]   days_r, days_nxt;
  logic [HOUR_W-1:0]   hour_r, hour_nxt;
  logic [MINUTE_W-1:0] minute_r, minute_nxt;
  logic [YEAR_W-1:0]   year_r, year_nxt;
  logic [6:0]          mod100_r, mod100_nxt;
  logic [8:0]          mod400_r, mod400_nxt;
  logic [MONTH_W-1:0]  month_r, month_nxt;

  // Output register.
  logic [YEAR_W-1:0]   oyear_r;
  logic [MONTH_W-1:0]  omonth_r;
  logic [DAY_W-1:0]    oday_r;
  logic [HOUR_W-1:0]   ohour_r;
  logic [MINUTE_W-1:0] ominute_r;
  logic [SECOND_W-1:0] osecond_r;
  logic [ZI_W-1:0]     ozone_r;

  // Datapath intermediates.
  logic signed [17:0]    off_secs;
  logic [TS_W-1:0]       off_ext;
  logic [TS_W-1:0]       divisor;
  logic [TS_W-1:0]       fix_prod;
  logic [TS_W-1:0]       fix_rem;
  logic                  fix_ge;
  logic [EST_DAY_W-1:0]  est_day;
  logic [EST_HOUR_W-1:0] est_hour;
  logic [EST_MIN_W-1:0]  est_min;
  logic                  leap;
  logic [8:0]            ylen;
  logic [DAY_W-1:0]      dim;

  assign zone_addr = AW'(in_zone_index);
  assign zone_ok   = 32'(in_zone_index) < ZONE_COUNT;

  // Table write and registered table read.
  always_ff @(posedge clk) begin
    if (cmd.wr && zone_ok) begin
      zone_mem[zone_addr] <= in_zone_offset_hours;
    end
    if (cmd.load) begin
      off_r <= zone_mem[zone_addr];
    end
  end

  // Offset in seconds; an index beyond the table applies no offset.
  assign off_secs = ok_r ? (18'(signed'(off_r)) * 18'sd3600) : 18'sd0;
  assign off_ext  = {{(TS_W - 18){off_secs[17]}}, off_secs};

  // Shared divider by a constant: the divisor and the product of the
  // estimated quotient with it, for the correction step.
  always_comb begin
    case (cmd.div_sel)
      DS_DAY: begin
        divisor  = SECS_PER_DAY;
        fix_prod = TS_W'(days_r) * SECS_PER_DAY;
      end
      DS_HOUR: begin
        divisor  = SECS_PER_HOUR;
        fix_prod = TS_W'(hour_r) * SECS_PER_HOUR;
      end
      DS_MIN: begin
        divisor  = SECS_PER_MIN;
        fix_prod = TS_W'(minute_r) * SECS_PER_MIN;
      end
      default: begin
        divisor  = SECS_PER_DAY;
        fix_prod = TS_W'(days_r) * SECS_PER_DAY;
      end
    endcase
  end
  assign fix_rem = rem_r - fix_prod;
  assign fix_ge  = fix_rem >= divisor;

  // Quotient estimates by reciprocal multiplication, exact or one low.
  assign est_day  = EST_DAY_W'(rem_r[TS_W-1:DAY_PRE]) * EST_DAY_W'(DAY_RECIP);
  assign est_hour = EST_HOUR_W'(rem_r[HOUR_SH-1:0]) * EST_HOUR_W'(HOUR_RECIP);
  assign est_min  = EST_MIN_W'(rem_r[MIN_SH-1:0]) * EST_MIN_W'(MIN_RECIP);

  // Gregorian leap rule from running year remainders.
  assign leap = (year_r[1:0] == 2'd0) && ((mod100_r != 7'd0) || (mod400_r == 9'd0));
  assign ylen = leap ? 9'd366 : 9'd365;
  assign dim  = month_len(month_r, leap);

  assign sts.year_done  = days_r < DAYS_W'(ylen);
  assign sts.month_done = (days_r < DAYS_W'(dim)) || (month_r == LAST_MONTH);

  // Next values of the working registers.
  always_comb begin
    rem_nxt    = rem_r;
    days_nxt   = days_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    year_nxt   = year_r;
    mod100_nxt = mod100_r;
    mod400_nxt = mod400_r;
    month_nxt  = month_r;
    if (cmd.load) begin
      year_nxt   = YEAR_W'(EPOCH_YEAR);
      mod100_nxt = MOD100_INIT;
      mod400_nxt = MOD400_INIT;
      month_nxt  = '0;
    end
    if (cmd.add) begin
      rem_nxt = ts_r + off_ext;
    end
    // Estimate step: take the quotient from the reciprocal product.
    if (cmd.div_en && !cmd.div_fix) begin
      case (cmd.div_sel)
        DS_DAY:  days_nxt   = est_day[DAY_SH +: DAYS_W];
        DS_HOUR: hour_nxt   = est_hour[HOUR_SH +: HOUR_W];
        DS_MIN:  minute_nxt = est_min[MIN_SH +: MINUTE_W];
        default: days_nxt   = days_r;
      endcase
    end
    // Correction step: form the remainder and bump a low estimate.
    if (cmd.div_en && cmd.div_fix) begin
      rem_nxt = fix_ge ? (fix_rem - divisor) : fix_rem;
      case (cmd.div_sel)
        DS_DAY:  days_nxt   = days_r + DAYS_W'(fix_ge);
        DS_HOUR: hour_nxt   = hour_r + HOUR_W'(fix_ge);
        DS_MIN:  minute_nxt = minute_r + MINUTE_W'(fix_ge);
        default: days_nxt   = days_r;
      endcase
    end
    if (cmd.year_en && !sts.year_done) begin
      days_nxt   = days_r - DAYS_W'(ylen);
      year_nxt   = year_r + YEAR_W'(1);
      mod100_nxt = (mod100_r == 7'd99) ? 7'd0 : mod100_r + 7'd1;
      mod400_nxt = (mod400_r == 9'd399) ? 9'd0 : mod400_r + 9'd1;
    end
    if (cmd.month_en && !sts.month_done) begin
      days_nxt  = days_r - DAYS_W'(dim);
      month_nxt = month_r + MONTH_W'(1);
    end
  end

  // Working and output registers (payload only, no reset).
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ts_r <= in_unix_time;
      zi_r <= in_zone_index;
      ok_r <= zone_ok;
    end
    rem_r    <= rem_nxt;
    days_r   <= days_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
    year_r   <= year_nxt;
    mod100_r <= mod100_nxt;
    mod400_r <= mod400_nxt;
    month_r  <= month_nxt;
    if (cmd.out_load) begin
      oyear_r   <= year_r;
      omonth_r  <= month_r + MONTH_W'(1);
      oday_r    <= days_r[DAY_W-1:0] + DAY_W'(1);
      ohour_r   <= hour_r;
      ominute_r <= minute_r;
      osecond_r <= rem_r[SECOND_W-1:0];
      ozone_r   <= zi_r;
    end
  end

  assign out_year      = oyear_r;
  assign out_month     = omonth_r;
  assign out_day       = oday_r;
  assign out_hour      = ohour_r;
  assign out_minute    = ominute_r;
  assign out_second    = osecond_r;
  assign out_zone_used = ozone_r;

endmodule

>>> sv/utz_ctrl.sv
`include "unix_time_to_zoned_date_time_macros.svh"

module utz_ctrl
  import utz_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_command,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Sequencer: table writes, load, offset add, three divisions, year and month stepping, and result hand-over.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.div_sel   = DS_DAY;
    cmd.div_fix   = (cnt_r == '0);
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_command) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_ADD;
          end
        end
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        cnt_nxt   = DIV_TOP;
        state_nxt = S_DIV_DAY;
      end
      S_DIV_DAY: begin
        cmd.div_en  = 1'b1;
        cmd.div_sel = DS_DAY;
        if (cnt_r == '0) begin
          cnt_nxt   = DIV_TOP;
          state_nxt = S_DIV_HOUR;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_DIV_HOUR: begin
        cmd.div_en  = 1'b1;
        cmd.div_sel = DS_HOUR;
        if (cnt_r == '0) begin
          cnt_nxt   = DIV_TOP;
          state_nxt = S_DIV_MIN;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_DIV_MIN: begin
        cmd.div_en  = 1'b1;
        cmd.div_sel = DS_MIN;
        if (cnt_r == '0) begin
          state_nxt = S_YEAR;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_YEAR: begin
        cmd.year_en = 1'b1;
        if (sts.year_done) begin
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        cmd.month_en = 1'b1;
        if (sts.month_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // Hand over only once the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A finished conversion never overwrites a result that is still waiting.
  `UTZ_ASSERT_NEXT(a_finish_holds, (state_r == S_FINISH) && out_valid_r && !out_ready, (state_r == S_FINISH) && out_valid_r, "finished result overwrote a pending transaction")
  // The day division hands over to the hour division with its first phase loaded.
  `UTZ_ASSERT_NEXT(a_day_to_hour, (state_r == S_DIV_DAY) && (cnt_r == '0), (state_r == S_DIV_HOUR) && (cnt_r == DIV_TOP), "day division did not hand over to hour division")
  // A conversion transaction starts the sequence.
  `UTZ_ASSERT_NEXT(a_start_conv, in_valid && in_ready && !in_command, state_r == S_ADD, "accepted conversion did not start")
  // A table write leaves the sequencer idle.
  `UTZ_ASSERT_NEXT(a_start_load, in_valid && in_ready && in_command, state_r == S_IDLE, "accepted table write left idle")
  // A result is loaded only from the last state.
  `UTZ_ASSERT_SAME(a_load_finish, cmd.out_load, state_r == S_FINISH, "result loaded outside the final state")

endmodule

>>> sv/unix_time_to_zoned_date_time.sv
// Converts a 32-bit Unix timestamp into a Gregorian date and time of day in
// one of ZONE_COUNT whole-hour time zones. A transaction with command 1 writes
// one zone offset into the table and gives no result; an entry must be
// written before a conversion uses it, and an index beyond the table applies
// offset zero. A conversion runs through the offset add, three divisions by a
// constant (days, hours, minutes), each a reciprocal estimate followed by a
// correction, and the year and month counters, which step one year or one
// month per cycle; the finished result then waits, if need be, for the
// previous result to be taken. One conversion is in flight at a time; the next
// transaction is accepted as soon as a result reaches the output register,
// even if that result has not yet been taken.
module unix_time_to_zoned_date_time
  import utz_pkg::*;
#(
  parameter int ZONE_COUNT = ZONE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic [TS_W-1:0]     in_unix_time,
  input  logic [ZI_W-1:0]     in_zone_index,
  input  logic [OFF_W-1:0]    in_zone_offset_hours,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [YEAR_W-1:0]   out_year,
  output logic [MONTH_W-1:0]  out_month,
  output logic [DAY_W-1:0]    out_day,
  output logic [HOUR_W-1:0]   out_hour,
  output logic [MINUTE_W-1:0] out_minute,
  output logic [SECOND_W-1:0] out_second,
  output logic [ZI_W-1:0]     out_zone_used
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  utz_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Zone table, divider, calendar counters and output register.
  utz_dp #(
    .ZONE_COUNT (ZONE_COUNT)
  ) u_dp (
    .clk                  (clk),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_unix_time         (in_unix_time),
    .in_zone_index        (in_zone_index),
    .in_zone_offset_hours (in_zone_offset_hours),
    .out_year             (out_year),
    .out_month            (out_month),
    .out_day              (out_day),
    .out_hour             (out_hour),
    .out_minute           (out_minute),
    .out_second           (out_second),
    .out_zone_used        (out_zone_used)
  );

endmodule

>>> tb/sv/zoned_time_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the converter, keeps its own copy of the zone
// offset table, predicts each conversion and compares every result with it.
module zoned_time_checker
  import utz_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_command,
  input  logic [TS_W-1:0]     in_unix_time,
  input  logic [ZI_W-1:0]     in_zone_index,
  input  logic [OFF_W-1:0]    in_zone_offset_hours,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [YEAR_W-1:0]   out_year,
  input  logic [MONTH_W-1:0]  out_month,
  input  logic [DAY_W-1:0]    out_day,
  input  logic [HOUR_W-1:0]   out_hour,
  input  logic [MINUTE_W-1:0] out_minute,
  input  logic [SECOND_W-1:0] out_second,
  input  logic [ZI_W-1:0]     out_zone_used,
  output int                  fail_count,
  output int                  pending_count,
  output int                  checked_count
);

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic [ZI_W-1:0]     zone_used;
  } local_time_t;

  // Offsets in whole hours, as the table in the block holds them.
  logic signed [OFF_W-1:0] zone_hours [ZONE_COUNT_DEF];

  // Local times still owed by the block, oldest first.
  local_time_t awaited_times [$];

  int errors  = 0;
  int waiting = 0;
  int checked = 0;

  assign fail_count    = errors;
  assign pending_count = waiting;
  assign checked_count = checked;

  function automatic bit is_leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Month index 0 is January.
  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    case (m)
      1:           return is_leap_year(y) ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  // Shifts the stamp by the zone's offset and splits it into a calendar date
  // and a time of day.
  function automatic local_time_t zoned_time_of(logic [TS_W-1:0] stamp,
                                                logic [ZI_W-1:0] zone);
    local_time_t             r;
    logic signed [OFF_W-1:0] shift_h;
    logic [TS_W-1:0]         shifted;
    int unsigned             days;
    int unsigned             sod;
    int unsigned             yr;
    int unsigned             mon;
    int unsigned             ylen;
    shift_h = '0;
    if (int'(zone) < ZONE_COUNT_DEF) begin
      shift_h = zone_hours[zone];
    end
    // The shift wraps modulo 2^32 in both directions.
    shifted = stamp + TS_W'(int'(shift_h) * 3600);
    days = shifted / 32'd86400;
    sod  = shifted % 32'd86400;
    // Step whole years from the epoch, then whole months.
    yr   = EPOCH_YEAR;
    ylen = is_leap_year(yr) ? 366 : 365;
    while (days >= ylen) begin
      days -= ylen;
      yr++;
      ylen = is_leap_year(yr) ? 366 : 365;
    end
    mon = 0;
    while (mon < 11 && days >= days_in_month(mon, yr)) begin
      days -= days_in_month(mon, yr);
      mon++;
    end
    r.year      = YEAR_W'(yr);
    r.month     = MONTH_W'(mon + 1);
    r.day       = DAY_W'(days + 1);
    r.hour      = HOUR_W'(sod / 3600);
    r.minute    = MINUTE_W'((sod % 3600) / 60);
    r.second    = SECOND_W'(sod % 60);
    r.zone_used = zone;
    return r;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Results are handled before new transactions, so a conversion accepted in
  // the same cycle as a result waits behind the older ones.
  always @(posedge clk) begin : monitor
    local_time_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (awaited_times.size() == 0) begin
          errors++;
          $display("%0t: result expected none, actual %0d-%0d-%0d %0d:%0d:%0d zone %0d",
                   $time, out_year, out_month, out_day, out_hour, out_minute,
                   out_second, out_zone_used);
        end else begin
          want = awaited_times.pop_front();
          checked++;
          check_field("year", want.year, out_year);
          check_field("month", want.month, out_month);
          check_field("day", want.day, out_day);
          check_field("hour", want.hour, out_hour);
          check_field("minute", want.minute, out_minute);
          check_field("second", want.second, out_second);
          check_field("zone_used", want.zone_used, out_zone_used);
        end
      end
      if (in_valid && in_ready) begin
        if (in_command) begin
          // A table write gives no result; an index past the table is ignored.
          if (int'(in_zone_index) < ZONE_COUNT_DEF) begin
            zone_hours[in_zone_index] = in_zone_offset_hours;
          end
        end else begin
          awaited_times.push_back(zoned_time_of(in_unix_time, in_zone_index));
        end
      end
    end
    waiting <= awaited_times.size();
  end

endmodule

>>> tb/sv/tb_unix_time_to_zoned_date_time.sv
`timescale 1ns / 1ps

module tb_unix_time_to_zoned_date_time;
  import utz_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int PHASE_ITEMS = 617;
  localparam int DRAIN_CYCLES = 250;

  localparam logic CMD_CONVERT = 1'b0;
  localparam logic CMD_LOAD    = 1'b1;

  // Start of 2000-01-01 and of 2100-01-01, both in UTC.
  localparam logic [TS_W-1:0] Y2000_START = 32'd946684800;
  localparam logic [TS_W-1:0] Y2100_START = 32'd4102444800;
  localparam logic [TS_W-1:0] STAMP_MAX   = 32'hFFFF_FFFF;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_command;
  logic [TS_W-1:0]     in_unix_time;
  logic [ZI_W-1:0]     in_zone_index;
  logic [OFF_W-1:0]    in_zone_offset_hours;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [YEAR_W-1:0]   out_year;
  logic [MONTH_W-1:0]  out_month;
  logic [DAY_W-1:0]    out_day;
  logic [HOUR_W-1:0]   out_hour;
  logic [MINUTE_W-1:0] out_minute;
  logic [SECOND_W-1:0] out_second;
  logic [ZI_W-1:0]     out_zone_used;

  int fail_count;
  int pending_count;
  int checked_count;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int conversions_sent = 0;
  int loads_sent = 0;
  bit zone_loaded [ZONE_COUNT_DEF];

  unix_time_to_zoned_date_time i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_command           (in_command),
    .in_unix_time         (in_unix_time),
    .in_zone_index        (in_zone_index),
    .in_zone_offset_hours (in_zone_offset_hours),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_year             (out_year),
    .out_month            (out_month),
    .out_day              (out_day),
    .out_hour             (out_hour),
    .out_minute           (out_minute),
    .out_second           (out_second),
    .out_zone_used        (out_zone_used)
  );

  zoned_time_checker i_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_command           (in_command),
    .in_unix_time         (in_unix_time),
    .in_zone_index        (in_zone_index),
    .in_zone_offset_hours (in_zone_offset_hours),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_year             (out_year),
    .out_month            (out_month),
    .out_day              (out_day),
    .out_hour             (out_hour),
    .out_minute           (out_minute),
    .out_second           (out_second),
    .out_zone_used        (out_zone_used),
    .fail_count           (fail_count),
    .pending_count        (pending_count),
    .checked_count        (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random according to the current idle rate.
  always @(posedge clk) begin
    out_ready <= rst_n && (int'($urandom_range(99)) >= recv_idle_pct);
  end

  // Offers one transaction after a random gap and holds it until accepted.
  task automatic send_item(logic cmd, logic [TS_W-1:0] stamp, logic [ZI_W-1:0] zone,
                           logic [OFF_W-1:0] hours);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_command           <= cmd;
    in_unix_time         <= stamp;
    in_zone_index        <= zone;
    in_zone_offset_hours <= hours;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_LOAD) begin
      loads_sent++;
      zone_loaded[zone] = 1'b1;
    end else begin
      conversions_sent++;
    end
  endtask

  // The stamp field of a load and the offset field of a conversion are
  // don't-cares, so they carry random bits.
  task automatic load_zone(logic [ZI_W-1:0] zone, logic [OFF_W-1:0] hours);
    send_item(CMD_LOAD, $urandom, zone, hours);
  endtask

  task automatic convert(logic [TS_W-1:0] stamp, logic [ZI_W-1:0] zone);
    send_item(CMD_CONVERT, stamp, zone, OFF_W'($urandom));
  endtask

  // Holds the sender off until every owed result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Stamps lean toward the ends of the range and toward day boundaries, where
  // the zone shift moves the date across days, months and years.
  function automatic logic [TS_W-1:0] pick_stamp();
    logic [63:0] day_start;
    logic [63:0] sod;
    day_start = 64'($urandom_range(49710)) * 64'd86400;
    case ($urandom_range(3))
      0:       sod = 64'd0;
      1:       sod = 64'd86399;
      2:       sod = 64'($urandom_range(23)) * 64'd3600 + ($urandom_range(1) ? 64'd3599 : 64'd0);
      default: sod = 64'($urandom_range(86399));
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4:          return TS_W'($urandom_range(200000));
      5:          return STAMP_MAX - TS_W'($urandom_range(200000));
      default:    return TS_W'(day_start + sod);
    endcase
  endfunction

  // Mostly conversions through loaded zones, with table rewrites mixed in.
  task automatic random_item();
    logic [ZI_W-1:0]  zone;
    logic [OFF_W-1:0] hours;
    zone = ZI_W'($urandom_range(ZONE_COUNT_DEF - 1));
    if ($urandom_range(4) == 0 || !zone_loaded[zone]) begin
      if ($urandom_range(4) == 0) begin
        hours = OFF_W'($urandom);
      end else begin
        hours = OFF_W'(int'($urandom_range(26)) - 12);
      end
      load_zone(zone, hours);
    end else begin
      convert(pick_stamp(), zone);
    end
  endtask

  // Ends the run if the block stops making progress.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped after %0d cycles with %0d results outstanding.",
             CYCLE_LIMIT, pending_count);
    $display("unix_time_to_zoned_date_time: mismatch");
    $finish;
  end

  initial begin : stimulus
    rst_n                <= 1'b0;
    in_valid             <= 1'b0;
    in_command           <= CMD_CONVERT;
    in_unix_time         <= '0;
    in_zone_index        <= '0;
    in_zone_offset_hours <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the table: zero, both ends of the legal range, both ends of the
    // five-bit pattern, and random legal offsets elsewhere.
    load_zone(ZI_W'(0), OFF_W'(0));
    load_zone(ZI_W'(1), OFF_W'(-12));
    load_zone(ZI_W'(2), OFF_W'(14));
    load_zone(ZI_W'(3), OFF_W'(-16));
    load_zone(ZI_W'(4), OFF_W'(15));
    for (int z = 5; z < ZONE_COUNT_DEF; z++) begin
      load_zone(ZI_W'(z), OFF_W'(int'($urandom_range(26)) - 12));
    end

    // Range ends, wrap in both directions, and the century leap rules.
    convert('0, ZI_W'(0));
    convert(STAMP_MAX, ZI_W'(0));
    convert('0, ZI_W'(1));
    convert(STAMP_MAX, ZI_W'(2));
    convert(Y2000_START + 32'd59 * 32'd86400, ZI_W'(0));
    convert(Y2100_START + 32'd59 * 32'd86400 - 32'd1, ZI_W'(0));
    convert(Y2100_START + 32'd59 * 32'd86400, ZI_W'(15));
    convert(32'd2147483647, ZI_W'(3));
    convert(STAMP_MAX, ZI_W'(4));
    wait_for_results();

    // Random traffic under three handshake profiles.
    send_idle_pct = 38;
    recv_idle_pct = 73;
    repeat (PHASE_ITEMS) random_item();
    wait_for_results();

    send_idle_pct = 73;
    recv_idle_pct = 38;
    repeat (PHASE_ITEMS) random_item();
    wait_for_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (PHASE_ITEMS) random_item();
    wait_for_results();

    // Leave time for any stray result to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d conversions and %0d zone table loads; %0d local times checked.",
             conversions_sent, loads_sent, checked_count);
    $display("Covered range ends, wrap both ways, century leap years and three idle profiles.");
    if (fail_count == 0) begin
      $display("unix_time_to_zoned_date_time: match");
    end else begin
      $display("unix_time_to_zoned_date_time: mismatch");
    end
    $finish;
  end

endmodule
